FILE: rtl/core/bmprle_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the BMP RLE decoder.
package bmprle_pkg;

   typedef logic [1:0]  opcode_type;
   typedef logic [7:0]  byte_type;
   typedef logic [23:0] color_type;
   typedef logic [15:0] pos_type;
   typedef logic [12:0] dim_type;
   typedef logic [1:0]  csr_index_type;

   localparam opcode_type OP_STREAM  = 2'd0;
   localparam opcode_type OP_PALETTE = 2'd1;
   localparam opcode_type OP_NEW_IMG = 2'd2;

   localparam csr_index_type CSR_IMAGE_WIDTH  = 2'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 2'd1;
   localparam csr_index_type CSR_RLE_MODE     = 2'd2;

   localparam byte_type ESC_EOL   = 8'd0;
   localparam byte_type ESC_EOB   = 8'd1;
   localparam byte_type ESC_DELTA = 8'd2;

   localparam logic [3:0] NIB_MASK = 4'hF;

endpackage

FILE: rtl/core/bmprle_req_if.sv
`timescale 1ns / 1ps
// Input item channel: stream bytes, palette writes and image starts.
interface bmprle_req_if;
   import bmprle_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   byte_type   data_byte;
   byte_type   palette_slot;
   color_type  palette_color;

   modport source (output valid, opcode, data_byte, palette_slot, palette_color,
                   input ready);
   modport sink   (input valid, opcode, data_byte, palette_slot, palette_color,
                   output ready);
endinterface

FILE: rtl/core/bmprle_rsp_if.sv
`timescale 1ns / 1ps
// Result item channel: run descriptors and the end marker.
interface bmprle_rsp_if;
   import bmprle_pkg::*;

   logic       valid;
   logic       ready;
   pos_type    line_number;
   pos_type    start_column;
   byte_type   run_length;
   color_type  first_color;
   color_type  second_color;
   logic       image_end;

   modport source (output valid, line_number, start_column, run_length, first_color,
                   second_color, image_end, input ready);
   modport sink   (input valid, line_number, start_column, run_length, first_color,
                   second_color, image_end, output ready);
endinterface

FILE: rtl/core/bmp_rle_decoder.sv
`timescale 1ns / 1ps
// BMP RLE8/RLE4 run decoder top level.
// req_if takes one item per cycle while ready is high: a compressed stream
// byte, a palette write or the start of a new image. rsp_if gives run
// descriptors (line from the bottom, start column, clipped length, two
// alternating colors) and one end marker with image_end set. csr_* writes
// image_width, image_height and rle_mode; write them only while the decoder
// is idle. Throughput is one item per cycle while req_if.ready is high.
// The parser state updates when an item is accepted and issues the palette
// reads; the palette RAM answers into the palette read stage, and the result
// then moves into the output register that drives rsp_if.
// When rsp_if is stalled, the output register holds and one more result waits
// in the palette read stage; items that make no result keep flowing until
// that stage fills, then req_if.ready drops.
// Reset clears the parser, position, finished flag and registers (width 1,
// height 1, RLE8); palette contents are kept across reset and new images and
// are undefined until written.
module bmp_rle_decoder #(
   parameter int MAX_WIDTH       = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   bmprle_req_if.sink                req_if,
   bmprle_rsp_if.source              rsp_if,
   input  logic                      csr_write_enable,
   input  bmprle_pkg::csr_index_type csr_index,
   input  bmprle_pkg::dim_type       csr_write_data
);
   import bmprle_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam logic [16:0] MAX_W = 17'(MAX_WIDTH);
   localparam logic [8:0]  PAL_N = 9'(PALETTE_ENTRIES);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ENC  = 3'd1;
   localparam logic [2:0] PH_ESC  = 3'd2;
   localparam logic [2:0] PH_DX   = 3'd3;
   localparam logic [2:0] PH_DY   = 3'd4;
   localparam logic [2:0] PH_ABS  = 3'd5;
   localparam logic [2:0] PH_PAD  = 3'd6;

   function automatic pos_type sat_add(input pos_type a, input pos_type b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // configuration
   dim_type width_ff, height_ff;
   logic    mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         mode_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            CSR_RLE_MODE:     mode_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // parser state
   logic [2:0] phase_ff, phase_in;
   byte_type   pending_ff, pending_in;
   byte_type   abs_left_ff, abs_left_in;
   logic       pad_ff, pad_in;
   pos_type    col_ff, col_in;
   pos_type    line_ff, line_in;
   logic       finished_ff, finished_in;

   // palette read stage
   logic       s1_valid_ff, s1_valid_in;
   pos_type    s1_line_ff, s1_col_ff;
   byte_type   s1_len_ff;
   logic       s1_end_ff, s1_rle4_ff, s1_oor_a_ff, s1_oor_b_ff;

   // output register
   logic       out_valid_ff, out_valid_in;
   pos_type    out_line_ff, out_col_ff;
   byte_type   out_len_ff;
   color_type  out_c1_ff, out_c2_ff;
   logic       out_end_ff;

   logic       s1_move, accept;
   opcode_type op;
   byte_type   b;
   logic       rle4;

   assign s1_move    = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign accept     = req_if.valid && req_if.ready;
   assign op         = req_if.opcode;
   assign b          = req_if.data_byte;
   assign rle4       = mode_ff;

   // palette addressing
   byte_type idx_a, idx_b;
   logic     oor_a, oor_b;
   logic     pal_we;

   assign idx_a  = rle4 ? {4'd0, b[7:4]} : b;
   assign idx_b  = {4'd0, b[3:0] & NIB_MASK};
   assign oor_a  = {1'b0, idx_a} >= PAL_N;
   assign oor_b  = {1'b0, idx_b} >= PAL_N;
   assign pal_we = accept && (op == OP_PALETTE) && ({1'b0, req_if.palette_slot} < PAL_N);

   color_type q_a, q_b;

   bmprle_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
      .clock     (clock),
      .wr_en     (pal_we),
      .wr_addr   (req_if.palette_slot[AW-1:0]),
      .wr_data   (req_if.palette_color),
      .rd_en     (accept),
      .rd_addr_a (idx_a[AW-1:0]),
      .rd_addr_b (idx_b[AW-1:0]),
      .rd_data_a (q_a),
      .rd_data_b (q_b)
   );

   // run placement
   logic        do_run;
   byte_type    run_n;
   pos_type     eff_w, room;
   byte_type    vis;
   logic        line_ok;
   logic        emit_run, emit_end;

   assign eff_w   = ({4'd0, width_ff} > MAX_W) ? MAX_W[15:0] : {3'd0, width_ff};
   assign room    = (col_ff < eff_w) ? (eff_w - col_ff) : 16'd0;
   assign vis     = (room > {8'd0, run_n}) ? run_n : room[7:0];
   assign line_ok = line_ff < {3'd0, height_ff};

   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      abs_left_in = abs_left_ff;
      pad_in      = pad_ff;
      col_in      = col_ff;
      line_in     = line_ff;
      finished_in = finished_ff;
      do_run      = 1'b0;
      run_n       = pending_ff;
      emit_end    = 1'b0;
      if (accept && op == OP_NEW_IMG) begin
         phase_in    = PH_IDLE;
         pending_in  = 8'd0;
         abs_left_in = 8'd0;
         pad_in      = 1'b0;
         col_in      = 16'd0;
         line_in     = 16'd0;
         finished_in = 1'b0;
      end else if (accept && op == OP_STREAM && !finished_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (b != 8'd0) begin
                  pending_in = b;
                  phase_in   = PH_ENC;
               end else begin
                  phase_in = PH_ESC;
               end
            end
            PH_ENC: begin
               do_run     = 1'b1;
               run_n      = pending_ff;
               pending_in = 8'd0;
               phase_in   = PH_IDLE;
            end
            PH_ESC: begin
               priority if (b == ESC_EOL) begin
                  col_in   = 16'd0;
                  line_in  = sat_add(line_ff, 16'd1);
                  phase_in = PH_IDLE;
               end else if (b == ESC_EOB) begin
                  finished_in = 1'b1;
                  emit_end    = 1'b1;
                  phase_in    = PH_IDLE;
               end else if (b == ESC_DELTA) begin
                  phase_in = PH_DX;
               end else begin
                  abs_left_in = b;
                  pad_in      = rle4 ? (b[1] ^ b[0]) : b[0];
                  phase_in    = PH_ABS;
               end
            end
            PH_DX: begin
               col_in   = sat_add(col_ff, {8'd0, b});
               phase_in = PH_DY;
            end
            PH_DY: begin
               line_in  = sat_add(line_ff, {8'd0, b});
               phase_in = PH_IDLE;
            end
            PH_ABS: begin
               do_run = 1'b1;
               if (rle4) begin
                  run_n = (abs_left_ff >= 8'd2) ? 8'd2 : abs_left_ff;
               end else begin
                  run_n = (abs_left_ff != 8'd0) ? 8'd1 : 8'd0;
               end
               abs_left_in = abs_left_ff - run_n;
               if (abs_left_in == 8'd0) begin
                  phase_in = pad_ff ? PH_PAD : PH_IDLE;
               end
            end
            PH_PAD: begin
               pad_in   = 1'b0;
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
         if (do_run) begin
            col_in = col_ff + {8'd0, vis};
         end
      end
   end

   assign emit_run = do_run && (vis != 8'd0) && line_ok;

   always_comb begin
      if (accept) begin
         s1_valid_in = emit_run || emit_end;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = s1_move ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pending_ff   <= 8'd0;
         abs_left_ff  <= 8'd0;
         pad_ff       <= 1'b0;
         col_ff       <= 16'd0;
         line_ff      <= 16'd0;
         finished_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         abs_left_ff  <= abs_left_in;
         pad_ff       <= pad_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         finished_ff  <= finished_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_line_ff  <= line_ff;
         s1_col_ff   <= col_ff;
         s1_len_ff   <= emit_end ? 8'd0 : vis;
         s1_end_ff   <= emit_end;
         s1_rle4_ff  <= rle4;
         s1_oor_a_ff <= oor_a;
         s1_oor_b_ff <= oor_b;
      end
   end

   color_type pal_a, pal_b;
   assign pal_a = s1_oor_a_ff ? 24'd0 : q_a;
   assign pal_b = s1_oor_b_ff ? 24'd0 : q_b;

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_line_ff <= s1_line_ff;
         out_col_ff  <= s1_col_ff;
         out_len_ff  <= s1_len_ff;
         out_end_ff  <= s1_end_ff;
         out_c1_ff   <= s1_end_ff ? 24'd0 : pal_a;
         out_c2_ff   <= s1_end_ff ? 24'd0 : (s1_rle4_ff ? pal_b : pal_a);
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.line_number  = out_line_ff;
   assign rsp_if.start_column = out_col_ff;
   assign rsp_if.run_length   = out_len_ff;
   assign rsp_if.first_color  = out_c1_ff;
   assign rsp_if.second_color = out_c2_ff;
   assign rsp_if.image_end    = out_end_ff;

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff |-> out_len_ff == 8'd0 && out_c1_ff == 24'd0
                                     && out_c2_ff == 24'd0)
      else $error("end marker carries run data");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_end_ff |-> out_len_ff != 8'd0)
      else $error("empty run emitted");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff && accept && op == OP_STREAM |=> !s1_valid_ff)
      else $error("result produced after end of bitmap");

   a_abs_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ABS |-> abs_left_ff != 8'd0)
      else $error("absolute run with nothing left");

endmodule

FILE: rtl/core/bmprle_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module bmprle_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

FILE: tb/sv/bmprle_checker.sv
`timescale 1ns / 1ps
// Run descriptor checker: predicts decoder output from accepted items and compares it.
module bmprle_checker
   import bmprle_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic          clock,
   input  logic          reset,
   bmprle_req_if         req_mon,
   bmprle_rsp_if         rsp_mon,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  dim_type       csr_write_data,
   output int            fail_count,
   output int            pending_runs
);

   localparam dim_type WIDTH_CAP = dim_type'(MAX_WIDTH);

   localparam logic [2:0] WAIT_CODE   = 3'd0;
   localparam logic [2:0] WAIT_PIXEL  = 3'd1;
   localparam logic [2:0] WAIT_ESCAPE = 3'd2;
   localparam logic [2:0] WAIT_DX     = 3'd3;
   localparam logic [2:0] WAIT_DY     = 3'd4;
   localparam logic [2:0] ABS_PIXELS  = 3'd5;
   localparam logic [2:0] ABS_PAD     = 3'd6;

   typedef struct {
      pos_type   line_number;
      pos_type   start_column;
      byte_type  run_length;
      color_type first_color;
      color_type second_color;
      logic      image_end;
   } run_desc_type;

   run_desc_type expected_runs[$];
   color_type    palette[256];
   dim_type      width_reg;
   dim_type      height_reg;
   logic         rle4_reg;
   logic [2:0]   state;
   byte_type     run_count;
   byte_type     abs_left;
   logic         pad_due;
   logic         image_done;
   pos_type      col_pos;
   pos_type      line_pos;

   function automatic pos_type sat_add(pos_type a, pos_type b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic int field_differs(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic clear_image();
      state      = WAIT_CODE;
      run_count  = '0;
      abs_left   = '0;
      pad_due    = 1'b0;
      col_pos    = '0;
      line_pos   = '0;
      image_done = 1'b0;
   endtask

   task automatic place_run(byte_type count, color_type c_even, color_type c_odd);
      dim_type      span;
      pos_type      vis;
      run_desc_type run;
      span = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
      vis  = '0;
      if (col_pos < 16'(span)) begin
         vis = 16'(span) - col_pos;
         if (vis > 16'(count)) vis = 16'(count);
      end
      run.line_number  = line_pos;
      run.start_column = col_pos;
      run.run_length   = vis[7:0];
      run.first_color  = c_even;
      run.second_color = c_odd;
      run.image_end    = 1'b0;
      col_pos = sat_add(col_pos, vis);
      if (vis != 0 && line_pos < 16'(height_reg)) expected_runs.push_back(run);
   endtask

   task automatic decode_item(opcode_type op, byte_type b, byte_type slot, color_type color);
      color_type    c_hi;
      color_type    c_lo;
      byte_type     take;
      run_desc_type marker;
      c_hi = rle4_reg ? palette[b >> 4] : palette[b];
      c_lo = rle4_reg ? palette[b & {4'h0, NIB_MASK}] : palette[b];
      case (op)
         OP_PALETTE: palette[slot] = color;
         OP_NEW_IMG: clear_image();
         OP_STREAM: if (!image_done) begin
            case (state)
               WAIT_CODE: begin
                  if (b != 8'd0) begin
                     run_count = b;
                     state = WAIT_PIXEL;
                  end else begin
                     state = WAIT_ESCAPE;
                  end
               end
               WAIT_PIXEL: begin
                  place_run(run_count, c_hi, c_lo);
                  run_count = '0;
                  state = WAIT_CODE;
               end
               WAIT_ESCAPE: begin
                  case (b)
                     ESC_EOL: begin
                        col_pos  = '0;
                        line_pos = sat_add(line_pos, 16'd1);
                        state    = WAIT_CODE;
                     end
                     ESC_EOB: begin
                        image_done = 1'b1;
                        state = WAIT_CODE;
                        marker.line_number  = line_pos;
                        marker.start_column = col_pos;
                        marker.run_length   = '0;
                        marker.first_color  = '0;
                        marker.second_color = '0;
                        marker.image_end    = 1'b1;
                        expected_runs.push_back(marker);
                     end
                     ESC_DELTA: state = WAIT_DX;
                     default: begin
                        abs_left = b;
                        pad_due  = rle4_reg ? (b[1:0] == 2'd1 || b[1:0] == 2'd2) : b[0];
                        state    = ABS_PIXELS;
                     end
                  endcase
               end
               WAIT_DX: begin
                  col_pos = sat_add(col_pos, 16'(b));
                  state = WAIT_DY;
               end
               WAIT_DY: begin
                  line_pos = sat_add(line_pos, 16'(b));
                  state = WAIT_CODE;
               end
               ABS_PIXELS: begin
                  if (rle4_reg) take = (abs_left >= 8'd2) ? 8'd2 : abs_left;
                  else take = (abs_left != 8'd0) ? 8'd1 : 8'd0;
                  place_run(take, c_hi, c_lo);
                  abs_left = abs_left - take;
                  if (abs_left == 8'd0) state = pad_due ? ABS_PAD : WAIT_CODE;
               end
               ABS_PAD: begin
                  pad_due = 1'b0;
                  state = WAIT_CODE;
               end
               default: state = WAIT_CODE;
            endcase
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      run_desc_type want;
      int           misses;
      misses = 0;
      if (reset) begin
         clear_image();
         width_reg  = 13'd1;
         height_reg = 13'd1;
         rle4_reg   = 1'b0;
         expected_runs.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_write_data;
               CSR_IMAGE_HEIGHT: height_reg = csr_write_data;
               CSR_RLE_MODE:     rle4_reg   = csr_write_data[0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected run item: line %0d column %0d length %0d",
                      rsp_mon.line_number, rsp_mon.start_column, rsp_mon.run_length);
               misses++;
            end else begin
               want = expected_runs.pop_front();
               misses += field_differs("line_number", 24'(want.line_number),
                                       24'(rsp_mon.line_number));
               misses += field_differs("start_column", 24'(want.start_column),
                                       24'(rsp_mon.start_column));
               misses += field_differs("run_length", 24'(want.run_length),
                                       24'(rsp_mon.run_length));
               misses += field_differs("first_color", want.first_color, rsp_mon.first_color);
               misses += field_differs("second_color", want.second_color,
                                       rsp_mon.second_color);
               misses += field_differs("image_end", 24'(want.image_end), 24'(rsp_mon.image_end));
            end
         end
         if (req_mon.valid && req_mon.ready)
            decode_item(req_mon.opcode, req_mon.data_byte, req_mon.palette_slot,
                        req_mon.palette_color);
      end
      fail_count   <= fail_count + misses;
      pending_runs <= expected_runs.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, stimulus, stalls and verdict.
module tb_top;
   import bmprle_pkg::*;

   localparam int            CYCLE_LIMIT  = 400000;
   localparam int            DRAIN_CYCLES = 6;
   localparam csr_index_type CSR_UNMAPPED = 2'd3;
   localparam opcode_type    OP_UNUSED    = 2'd3;
   localparam byte_type      CODE_ESCAPE  = 8'h00;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_IMAGE_WIDTH;
   dim_type       csr_write_data = '0;
   int            fail_count;
   int            pending_runs;
   int            cycle_count;
   int            items_sent;
   logic          rle4_mode;
   logic          req_burst;
   logic          rsp_burst;

   bmprle_req_if req_ch();
   bmprle_rsp_if rsp_ch();

   bmp_rle_decoder i_dut (
      .clock,
      .reset,
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_write_enable,
      .csr_index,
      .csr_write_data
   );

   bmprle_checker i_checker (
      .clock,
      .reset,
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .csr_write_enable,
      .csr_index,
      .csr_write_data,
      .fail_count,
      .pending_runs
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      rsp_burst = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 7);
         if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_item(opcode_type op, byte_type b, byte_type slot, color_type color);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.data_byte     <= b;
      req_ch.palette_slot  <= slot;
      req_ch.palette_color <= color;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic stream_byte(byte_type b);
      send_item(OP_STREAM, b, byte_type'($urandom), color_type'($urandom));
      items_sent++;
   endtask

   task automatic write_palette(byte_type slot, color_type color);
      send_item(OP_PALETTE, byte_type'($urandom), slot, color);
      items_sent++;
   endtask

   task automatic start_image();
      send_item(OP_NEW_IMG, byte_type'($urandom), byte_type'($urandom), color_type'($urandom));
      items_sent++;
   endtask

   task automatic encoded_run(byte_type count, byte_type pixels);
      stream_byte(count);
      stream_byte(pixels);
   endtask

   task automatic absolute_run(byte_type count);
      int bytes;
      stream_byte(CODE_ESCAPE);
      stream_byte(count);
      bytes = rle4_mode ? (int'(count) + 1) / 2 : int'(count);
      repeat (bytes) stream_byte(byte_type'($urandom));
      if (rle4_mode ? (count[1:0] == 2'd1 || count[1:0] == 2'd2) : count[0])
         stream_byte(byte_type'($urandom));
   endtask

   task automatic end_of_line();
      stream_byte(CODE_ESCAPE);
      stream_byte(ESC_EOL);
   endtask

   task automatic delta(byte_type dx, byte_type dy);
      stream_byte(CODE_ESCAPE);
      stream_byte(ESC_DELTA);
      stream_byte(dx);
      stream_byte(dy);
   endtask

   task automatic end_of_bitmap();
      stream_byte(CODE_ESCAPE);
      stream_byte(ESC_EOB);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_runs != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, dim_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(dim_type w, dim_type h, logic mode);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_RLE_MODE, dim_type'(mode));
      rle4_mode = mode;
      start_image();
   endtask

   task automatic random_phase(int count);
      int stop;
      int pick;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            encoded_run(($urandom_range(0, 3) == 0) ? byte_type'($urandom_range(1, 255))
                                                    : byte_type'($urandom_range(1, 12)),
                        byte_type'($urandom));
         end else if (pick < 53) begin
            absolute_run(($urandom_range(0, 7) == 0) ? byte_type'($urandom_range(3, 255))
                                                     : byte_type'($urandom_range(3, 16)));
         end else if (pick < 62) begin
            end_of_line();
         end else if (pick < 70) begin
            delta(($urandom_range(0, 7) == 0) ? byte_type'($urandom)
                                              : byte_type'($urandom_range(0, 15)),
                  ($urandom_range(0, 7) == 0) ? byte_type'($urandom)
                                              : byte_type'($urandom_range(0, 2)));
         end else if (pick < 74) begin
            end_of_bitmap();
            // bytes after the end marker are dropped by the decoder
            repeat ($urandom_range(0, 3))
               send_item(OP_STREAM, byte_type'($urandom), byte_type'($urandom),
                         color_type'($urandom));
            start_image();
         end else if (pick < 82) begin
            write_palette(byte_type'($urandom), color_type'($urandom));
         end else if (pick < 85) begin
            start_image();
         end else if (pick < 93) begin
            stream_byte(byte_type'($urandom));
         end else if (pick < 96) begin
            send_item(OP_UNUSED, byte_type'($urandom), byte_type'($urandom),
                      color_type'($urandom));
         end else begin
            // absolute run cut short by a new image
            stream_byte(CODE_ESCAPE);
            stream_byte(byte_type'($urandom_range(3, 40)));
            repeat ($urandom_range(0, 3)) stream_byte(byte_type'($urandom));
            start_image();
         end
      end
   endtask

   initial begin
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= OP_STREAM;
      req_ch.data_byte     <= '0;
      req_ch.palette_slot  <= '0;
      req_ch.palette_color <= '0;
      rle4_mode = 1'b0;
      req_burst = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < 256; s++)
         write_palette(byte_type'(s), (s == 0) ? 24'h000000 : color_type'($urandom));

      configure(13'd16, 13'd4, 1'b0);
      encoded_run(8'd3, 8'h00);
      encoded_run(8'hFF, 8'hFF);
      delta(8'd5, 8'd1);
      absolute_run(8'd3);
      send_item(OP_UNUSED, 8'hA5, 8'h5A, 24'hFFFFFF);
      write_palette(8'h7F, 24'hFFFFFF);
      encoded_run(8'd2, 8'h7F);
      end_of_line();
      end_of_bitmap();
      send_item(OP_STREAM, 8'h05, 8'h00, 24'h000000);

      configure(13'd16, 13'd4, 1'b1);
      encoded_run(8'd5, 8'hAB);
      absolute_run(8'd5);
      absolute_run(8'd4);
      absolute_run(8'd3);
      encoded_run(8'd9, 8'hF0);
      end_of_bitmap();

      wait_idle();
      write_csr(CSR_UNMAPPED, dim_type'($urandom));

      configure(13'd1, 13'd1, 1'b0);
      random_phase(30);
      configure(13'd4096, 13'd4096, 1'b1);
      random_phase(30);
      configure(13'd8191, 13'd8191, 1'b0);
      random_phase(30);
      configure(13'd0, 13'd5, 1'b1);
      random_phase(25);
      configure(13'd40, 13'd0, 1'b0);
      random_phase(25);
      repeat (4) begin
         configure(dim_type'($urandom_range(1, 64)), dim_type'($urandom_range(1, 16)),
                   1'($urandom_range(0, 1)));
         random_phase(25);
      end

      // drive column and line into saturation, then probe both
      configure(13'd4096, 13'd4096, 1'($urandom_range(0, 1)));
      repeat (258) delta(8'hFF, 8'hFF);
      encoded_run(8'd5, byte_type'($urandom));
      end_of_bitmap();

      wait_idle();
      if (fail_count == 0 && pending_runs == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

FILE: bmp_rle_decoder.f
rtl/core/bmprle_pkg.sv
rtl/core/bmprle_req_if.sv
rtl/core/bmprle_rsp_if.sv
rtl/core/bmprle_ram.sv
rtl/core/bmp_rle_decoder.sv
tb/sv/bmprle_checker.sv
tb/sv/tb_top.sv
